[hw/rtl/bitmap_page_frame_allocator_unit_defines.svh]
// ----------------------------------------------------------------------------
// bitmap page frame allocator assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define BPFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bitmap page frame allocator package
// command and status codes, field widths and transfer payload types
// ----------------------------------------------------------------------------
package bpfa_pkg;

    // map size, fixed by the 12-bit page index of the transfers
    localparam int PAGE_COUNT = 4096;
    localparam int WORD_BITS  = 64;

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int PAGE_IDX_W = 12;
    localparam int COUNT_W    = 13;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_FREE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MARK_RSVD = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [PAGE_IDX_W-1:0] page_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [PAGE_IDX_W-1:0] granted_page;
        logic [COUNT_W-1:0]    free_pages;
        logic [COUNT_W-1:0]    used_pages;
        logic [COUNT_W-1:0]    reserved_pages;
    } t_out_item;

endpackage

[hw/rtl/bitmap_page_frame_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap page frame allocator
// one-bit-per-page frame map with free, used and reserved page counters
// ----------------------------------------------------------------------------
// The page map sits in a single-port-read, single-port-write memory of
// MAP_WORDS = ceil(PAGE_COUNT / WORD_BITS) words, a set bit meaning the page
// is taken. After reset a fill pass writes every word to all ones, one word a
// cycle, so the block takes no command until the fill pass is done. Commands
// are handled one at a time. Allocate scans the map through the memory read
// port, one word per cycle, checking each word from the registered read data,
// and stops at the lowest free page, or after the last word when the map is
// full. Free, mark free and mark reserved do one read-modify-write of a
// single word; an index out of range skips the map access. A finished result
// waits in an output register, and a new command is taken while it waits.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bpfa_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bpfa_pkg::t_out_item  o_out_data
);

    // map geometry
    localparam int PAGE_COUNT = bpfa_pkg::PAGE_COUNT;
    localparam int WORD_BITS  = bpfa_pkg::WORD_BITS;
    localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam int CW        = $clog2(PAGE_COUNT + 1);
    localparam int LAST_BITS = PAGE_COUNT - (MAP_WORDS - 1) * WORD_BITS;

    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(PAGE_COUNT);

    // pages past the end of the map in the last word never count as free
    localparam logic [WORD_BITS:0] LAST_MASK_W =
        ({{WORD_BITS{1'b0}}, 1'b1} << LAST_BITS) - {{WORD_BITS{1'b0}}, 1'b1};
    localparam logic [WORD_BITS-1:0] LAST_MASK = LAST_MASK_W[WORD_BITS-1:0];

    // sequencer states
    localparam logic [2:0] S_INIT  = 3'd0;  // fill pass after reset
    localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a command
    localparam logic [2:0] S_SCAN  = 3'd2;  // allocate: word-by-word search
    localparam logic [2:0] S_WRITE = 3'd3;  // allocate: mark the found page
    localparam logic [2:0] S_RD    = 3'd4;  // single-page commands: read word
    localparam logic [2:0] S_MOD   = 3'd5;  // single-page commands: update
    localparam logic [2:0] S_DONE  = 3'd6;  // hand result to output register

    logic [2:0]                  r_state;
    logic [AW-1:0]               r_addr;    // word being read
    logic [AW-1:0]               r_cur;     // word held in r_rdata while scanning
    logic                        r_have;    // r_rdata holds a scanned word
    logic [BW-1:0]               r_bit;
    logic [bpfa_pkg::CMD_W-1:0]  r_cmd;
    logic [WORD_BITS-1:0]        r_word;    // word with the free page found
    logic [bpfa_pkg::STATUS_W-1:0]   r_status;
    logic [bpfa_pkg::PAGE_IDX_W-1:0] r_grant;
    logic [CW-1:0]               r_free_cnt;
    logic [CW-1:0]               r_used_cnt;
    logic [CW-1:0]               r_rsvd_cnt;
    logic [CW-1:0]               n_free_cnt;
    logic [CW-1:0]               n_used_cnt;
    logic [CW-1:0]               n_rsvd_cnt;
    logic                        r_out_valid;
    bpfa_pkg::t_out_item         r_out;

    // page map memory
    logic [WORD_BITS-1:0]        r_map [MAP_WORDS];
    logic [WORD_BITS-1:0]        r_rdata;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [WORD_BITS-1:0]        wr_data;

    logic                        in_xfer;
    logic                        out_free;
    logic [31:0]                 page_ext;
    logic                        in_range;
    logic [AW-1:0]               in_word;
    logic [BW-1:0]               in_bit;
    logic [WORD_BITS-1:0]        scan_mask;
    logic [WORD_BITS-1:0]        free_bits;
    logic                        hit;
    logic [BW-1:0]               hit_bit;
    logic [WORD_BITS-1:0]        bit_sel;
    logic                        cur_taken;
    logic [31:0]                 grant_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // decode of the page index: word and bit within the map
    assign page_ext = {{(32 - bpfa_pkg::PAGE_IDX_W){1'b0}}, i_in_data.page_index};
    assign in_range = page_ext < 32'(PAGE_COUNT);
    assign in_word  = AW'(page_ext / WORD_BITS);
    assign in_bit   = BW'(page_ext % WORD_BITS);

    assign bit_sel   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << r_bit;
    assign cur_taken = r_rdata[r_bit];
    assign grant_ext = 32'(r_cur) * 32'(WORD_BITS) + 32'(r_bit);

    // free pages of the scanned word, page 0 never handed out
    always_comb begin
        scan_mask = '1;
        if (r_cur == LAST_WORD) begin
            scan_mask = scan_mask & LAST_MASK;
        end
        if (r_cur == '0) begin
            scan_mask[0] = 1'b0;
        end
        free_bits = ~r_rdata & scan_mask;
        hit       = |free_bits;
    end

    // lowest free bit of the word
    always_comb begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                hit_bit = BW'(i);
            end
        end
    end

    // map write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = '1;
        unique case (r_state)
            S_INIT: begin
                wr_en = 1'b1;
            end
            S_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = r_word | bit_sel;
            end
            S_MOD: begin
                wr_addr = r_addr;
                if (r_cmd == bpfa_pkg::CMD_MARK_RSVD) begin
                    wr_en   = !cur_taken;
                    wr_data = r_rdata | bit_sel;
                end else begin
                    wr_en   = cur_taken;
                    wr_data = r_rdata & ~bit_sel;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map[wr_addr] <= wr_data;
        end
        r_rdata <= r_map[r_addr];
    end

    // counter updates, saturating at zero and at the page count
    always_comb begin
        n_free_cnt = r_free_cnt;
        n_used_cnt = r_used_cnt;
        n_rsvd_cnt = r_rsvd_cnt;
        unique case (r_state)
            S_WRITE: begin
                n_free_cnt = (r_free_cnt != '0) ? r_free_cnt - CW'(1) : r_free_cnt;
                n_used_cnt = (r_used_cnt < COUNT_MAX) ? r_used_cnt + CW'(1) : r_used_cnt;
            end
            S_MOD: begin
                unique case (r_cmd)
                    bpfa_pkg::CMD_FREE: begin
                        if (cur_taken) begin
                            n_free_cnt = (r_free_cnt < COUNT_MAX) ?
                                         r_free_cnt + CW'(1) : r_free_cnt;
                            n_used_cnt = (r_used_cnt != '0) ?
                                         r_used_cnt - CW'(1) : r_used_cnt;
                        end
                    end
                    bpfa_pkg::CMD_MARK_FREE: begin
                        if (cur_taken) begin
                            n_free_cnt = (r_free_cnt < COUNT_MAX) ?
                                         r_free_cnt + CW'(1) : r_free_cnt;
                        end
                    end
                    bpfa_pkg::CMD_MARK_RSVD: begin
                        if (!cur_taken) begin
                            n_free_cnt = (r_free_cnt != '0) ?
                                         r_free_cnt - CW'(1) : r_free_cnt;
                        end
                        n_rsvd_cnt = (r_rsvd_cnt < COUNT_MAX) ?
                                     r_rsvd_cnt + CW'(1) : r_rsvd_cnt;
                    end
                    default: begin
                        n_free_cnt = r_free_cnt;
                    end
                endcase
            end
            default: begin
                n_free_cnt = r_free_cnt;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_addr     <= '0;
            r_have     <= 1'b0;
            r_free_cnt <= '0;
            r_used_cnt <= '0;
            r_rsvd_cnt <= '0;
        end else begin
            r_free_cnt <= n_free_cnt;
            r_used_cnt <= n_used_cnt;
            r_rsvd_cnt <= n_rsvd_cnt;
            unique case (r_state)
                S_INIT: begin
                    if (r_addr == LAST_WORD) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_have <= 1'b0;
                        if (i_in_data.command == bpfa_pkg::CMD_ALLOC) begin
                            r_addr  <= '0;
                            r_state <= S_SCAN;
                        end else if (!in_range) begin
                            r_state <= S_DONE;
                        end else begin
                            r_addr  <= in_word;
                            r_state <= S_RD;
                        end
                    end
                end
                S_SCAN: begin
                    // one read issued and one word checked per cycle
                    if (r_addr != LAST_WORD) begin
                        r_addr <= r_addr + AW'(1);
                    end
                    if (r_have && hit) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_cur  <= r_addr;
                        r_have <= 1'b1;
                        if (r_have && (r_cur == LAST_WORD)) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    // command payload and result fields
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_cmd    <= i_in_data.command;
                    r_bit    <= in_bit;
                    r_grant  <= '0;
                    r_status <= (i_in_data.command != bpfa_pkg::CMD_ALLOC && !in_range) ?
                                bpfa_pkg::ST_RANGE : bpfa_pkg::ST_OK;
                end
            end
            S_SCAN: begin
                if (r_have && hit) begin
                    r_word <= r_rdata;
                    r_bit  <= hit_bit;
                end else if (r_have && (r_cur == LAST_WORD)) begin
                    r_status <= bpfa_pkg::ST_NONE;
                end
            end
            S_WRITE: begin
                r_grant <= grant_ext[bpfa_pkg::PAGE_IDX_W-1:0];
            end
            S_MOD: begin
                if (r_cmd != bpfa_pkg::CMD_MARK_RSVD && !cur_taken) begin
                    r_status <= bpfa_pkg::ST_ALREADY_FREE;
                end
            end
            default: begin
                r_grant <= r_grant;
            end
        endcase
    end

    // output register, refilled while the previous result is being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.status         <= r_status;
            r_out.granted_page   <= r_grant;
            r_out.free_pages     <= bpfa_pkg::COUNT_W'(r_free_cnt);
            r_out.used_pages     <= bpfa_pkg::COUNT_W'(r_used_cnt);
            r_out.reserved_pages <= bpfa_pkg::COUNT_W'(r_rsvd_cnt);
        end
    end

endmodule

[hw/rtl/bpfa_checker.sv]
// ----------------------------------------------------------------------------
// bitmap page frame allocator port checker
// port-level checks on transfers and result ordering
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_unit_defines.svh"

module bpfa_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  bpfa_pkg::t_in_item   i_in_data,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  bpfa_pkg::t_out_item  o_out_data
);

    logic                               in_xfer;
    logic                               out_xfer;
    logic [1:0]                         r_pend;
    logic                               r_seen;
    logic [bpfa_pkg::COUNT_W-1:0]       r_last_rsvd;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // commands taken but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_seen <= 1'b0;
        end else begin
            r_pend <= r_pend + {1'b0, in_xfer} - {1'b0, out_xfer};
            if (out_xfer) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_last_rsvd <= o_out_data.reserved_pages;
        end
    end

    // a result only ever answers a command already taken
    `BPFA_ASSERT_IMPL(a_no_orphan_result, i_clk, i_rst_n, o_out_valid, r_pend != 2'd0, "result without command")

    // at most one command in work and one result waiting
    `BPFA_ASSERT_IMPL(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pend != 2'd3, "too many commands outstanding")

    // the reserved count only grows, by at most one page per result
    `BPFA_ASSERT_IMPL(a_rsvd_step, i_clk, i_rst_n, out_xfer && r_seen, (o_out_data.reserved_pages == r_last_rsvd) || (o_out_data.reserved_pages == r_last_rsvd + 13'd1), "reserved count stepped")

    // a held result stays put
    `BPFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker u_bpfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/bitmap_page_frame_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// bitmap page frame allocator testbench
// drives allocate, free and mark commands through the valid/stall input
// channel, predicts every reply from a bit-accurate page map of its own and
// checks each output transfer field by field, with random gaps and stalls
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit_tb;

    localparam int PAGE_TOTAL = bpfa_pkg::PAGE_COUNT;
    // slowest command is a full allocate scan: one word a cycle plus overhead
    localparam int SCAN_CYCLES = PAGE_TOTAL / 64 + 16;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    bpfa_pkg::t_in_item  in_data  = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    bpfa_pkg::t_out_item out_data;

    // predicted state of the frame map: a set bit means the page is taken
    bit [PAGE_TOTAL-1:0]          frame_taken = '1;
    logic [bpfa_pkg::COUNT_W-1:0] free_tally  = '0;
    logic [bpfa_pkg::COUNT_W-1:0] used_tally  = '0;
    logic [bpfa_pkg::COUNT_W-1:0] rsvd_tally  = '0;

    // replies predicted at input transfer, in arrival order
    bpfa_pkg::t_out_item awaited_replies[$];
    int                  err_count  = 0;
    int                  burst_left = 0;

    always #1 clk = ~clk;

    bitmap_page_frame_allocator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // reply predictor
    // ------------------------------------------------------------------------

    // counters saturate at zero and at the page total
    function automatic logic [bpfa_pkg::COUNT_W-1:0] step_up(
        input logic [bpfa_pkg::COUNT_W-1:0] v);
        return (v < PAGE_TOTAL) ? bpfa_pkg::COUNT_W'(v + 1) :
                                  bpfa_pkg::COUNT_W'(PAGE_TOTAL);
    endfunction

    function automatic logic [bpfa_pkg::COUNT_W-1:0] step_down(
        input logic [bpfa_pkg::COUNT_W-1:0] v);
        return (v > 0) ? bpfa_pkg::COUNT_W'(v - 1) : '0;
    endfunction

    // applies one command to the predicted map and returns the reply
    function automatic bpfa_pkg::t_out_item apply_command(input bpfa_pkg::t_in_item cmd);
        bpfa_pkg::t_out_item r;
        int                  pg;
        bit                  hit;
        r        = '0;
        r.status = bpfa_pkg::ST_OK;
        if (cmd.command == bpfa_pkg::CMD_ALLOC) begin
            // lowest free page above page zero, which stands for no page
            hit = 1'b0;
            pg  = 0;
            for (int i = 1; i < PAGE_TOTAL; i++) begin
                if (!hit && !frame_taken[i]) begin
                    hit = 1'b1;
                    pg  = i;
                end
            end
            if (hit) begin
                frame_taken[pg] = 1'b1;
                free_tally      = step_down(free_tally);
                used_tally      = step_up(used_tally);
                r.granted_page  = bpfa_pkg::PAGE_IDX_W'(pg);
            end else begin
                r.status = bpfa_pkg::ST_NONE;
            end
        end else if (int'(cmd.page_index) >= PAGE_TOTAL) begin
            // cannot be reached with a 12-bit index at the default size
            r.status = bpfa_pkg::ST_RANGE;
        end else if (cmd.command == bpfa_pkg::CMD_FREE) begin
            if (!frame_taken[cmd.page_index]) begin
                r.status = bpfa_pkg::ST_ALREADY_FREE;
            end else begin
                frame_taken[cmd.page_index] = 1'b0;
                free_tally = step_up(free_tally);
                used_tally = step_down(used_tally);
            end
        end else if (cmd.command == bpfa_pkg::CMD_MARK_FREE) begin
            if (!frame_taken[cmd.page_index]) begin
                r.status = bpfa_pkg::ST_ALREADY_FREE;
            end else begin
                frame_taken[cmd.page_index] = 1'b0;
                free_tally = step_up(free_tally);
            end
        end else begin
            if (!frame_taken[cmd.page_index]) begin
                frame_taken[cmd.page_index] = 1'b1;
                free_tally = step_down(free_tally);
            end
            rsvd_tally = step_up(rsvd_tally);
        end
        r.free_pages     = free_tally;
        r.used_pages     = used_tally;
        r.reserved_pages = rsvd_tally;
        return r;
    endfunction

    // every input transfer is predicted on the edge that accepts it
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall) begin
            awaited_replies.push_back(apply_command(in_data));
        end
    end

    // ------------------------------------------------------------------------
    // reply checker
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string fname,
                                          input logic [bpfa_pkg::COUNT_W-1:0] want,
                                          input logic [bpfa_pkg::COUNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk) begin
        bpfa_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected output transfer, expected none, got %h",
                         $time, out_data);
                err_count++;
            end else begin
                want = awaited_replies.pop_front();
                compare_field("status", bpfa_pkg::COUNT_W'(want.status),
                              bpfa_pkg::COUNT_W'(out_data.status));
                compare_field("granted_page", bpfa_pkg::COUNT_W'(want.granted_page),
                              bpfa_pkg::COUNT_W'(out_data.granted_page));
                compare_field("free_pages", want.free_pages, out_data.free_pages);
                compare_field("used_pages", want.used_pages, out_data.used_pages);
                compare_field("reserved_pages", want.reserved_pages,
                              out_data.reserved_pages);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver back-pressure: modes held for random spans, one of them quiet
    // ------------------------------------------------------------------------
    initial begin : out_stall_gen
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge clk);
                case (mode)
                    0: begin
                        out_stall <= 1'b0;
                    end
                    1: begin
                        out_stall <= ($urandom_range(0, 99) < 30);
                    end
                    2: begin
                        // long runs of stall
                        out_stall <= ($urandom_range(0, 99) < 75);
                    end
                    default: begin
                        out_stall <= ~out_stall;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender: one command per call, in bursts with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_command(input bpfa_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        // valid stays high from one transfer to the next inside a burst
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_op(input logic [bpfa_pkg::CMD_W-1:0] op, input int pg);
        bpfa_pkg::t_in_item it;
        it.command    = op;
        it.page_index = bpfa_pkg::PAGE_IDX_W'(pg);
        send_command(it);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // map comes out of reset fully taken with every counter at zero
    task automatic test_after_reset;
        send_op(bpfa_pkg::CMD_ALLOC, 4095);     // map full: no page
        send_op(bpfa_pkg::CMD_FREE, 5);         // taken page freed, used count held at zero
    endtask

    // seed the map the way a memory-map walk would
    task automatic test_mark_free;
        send_op(bpfa_pkg::CMD_MARK_FREE, 0);
        send_op(bpfa_pkg::CMD_MARK_FREE, 1);
        send_op(bpfa_pkg::CMD_MARK_FREE, 4095);
        send_op(bpfa_pkg::CMD_MARK_FREE, 2);
        send_op(bpfa_pkg::CMD_MARK_FREE, 1);    // already free
        send_op(bpfa_pkg::CMD_MARK_FREE, 2730); // alternating index bits
        send_op(bpfa_pkg::CMD_MARK_FREE, 1365);
    endtask

    // page zero is never granted; the last allocate walks the whole map
    task automatic test_allocate;
        repeat (7) send_op(bpfa_pkg::CMD_ALLOC, 0);
        send_op(bpfa_pkg::CMD_ALLOC, 4095);     // only page zero left: no page
    endtask

    task automatic test_free;
        send_op(bpfa_pkg::CMD_FREE, 2);
        send_op(bpfa_pkg::CMD_FREE, 2);         // already free
        send_op(bpfa_pkg::CMD_FREE, 0);         // page zero never handed out
    endtask

    // reserving a free page takes it; reserving a taken page only counts it
    task automatic test_reserve;
        send_op(bpfa_pkg::CMD_MARK_RSVD, 2);
        send_op(bpfa_pkg::CMD_MARK_RSVD, 2);
        send_op(bpfa_pkg::CMD_MARK_RSVD, 4095);
        send_op(bpfa_pkg::CMD_FREE, 2);         // reserved page freed like a used one
        send_op(bpfa_pkg::CMD_ALLOC, 0);
    endtask

    // mixed traffic, mostly on low pages so that allocate scans stay short
    task automatic test_random_traffic;
        bpfa_pkg::t_in_item it;
        int                 roll;
        repeat (1025) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                it.command = bpfa_pkg::CMD_ALLOC;
            end else if (roll < 60) begin
                it.command = bpfa_pkg::CMD_FREE;
            end else if (roll < 85) begin
                it.command = bpfa_pkg::CMD_MARK_FREE;
            end else begin
                it.command = bpfa_pkg::CMD_MARK_RSVD;
            end
            if ($urandom_range(0, 99) < 70) begin
                it.page_index = bpfa_pkg::PAGE_IDX_W'($urandom_range(0, 191));
            end else begin
                it.page_index = bpfa_pkg::PAGE_IDX_W'($urandom_range(0, PAGE_TOTAL - 1));
            end
            send_command(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // the fill pass after reset holds stall high; send_command waits it out
        test_after_reset();
        test_mark_free();
        test_allocate();
        test_free();
        test_reserve();
        test_random_traffic();
        in_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge clk);
        repeat (SCAN_CYCLES) @(posedge clk);
        if (err_count == 0 && awaited_replies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

[bitmap_page_frame_allocator_unit.f]
+incdir+hw/rtl
hw/rtl/bpfa_pkg.sv
hw/rtl/bitmap_page_frame_allocator_unit.sv
hw/rtl/bpfa_checker.sv
tb/bitmap_page_frame_allocator_unit_tb.sv
